### design/assert_macros.svh
// Assertion macros used by the top-k selector design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check an implication property on every clock edge outside of reset.
`define TKS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define TKS_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TKS_ASSERT(label, clk, rst_n, prop, msg)
`define TKS_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

### design/tks_pkg.sv
// Types, constants and the ranking function of the top-k selector.
`timescale 1ns / 1ps

package tks_pkg;

  localparam int SCORE_W = 32;
  localparam int ID_W    = 32;
  localparam int CAP_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFER_HIGHER = 2'd1;

  // Request operations
  localparam logic OP_CONSIDER = 1'b0;
  localparam logic OP_FINISH   = 1'b1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  // One kept candidate
  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           id;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{valid: 1'b0, score: '0, id: '0};

  // Per-cell control from the sequencer
  typedef struct packed {
    logic load_en;   // cell may take part in an insertion this cycle
    logic shift;     // cell takes its right neighbor's entry
  } cell_ctl_t;

  // True when (sa, ia) ranks strictly above (sb, ib)
  function automatic logic cand_better(logic signed [SCORE_W-1:0] sa, logic [ID_W-1:0] ia,
                                       logic signed [SCORE_W-1:0] sb, logic [ID_W-1:0] ib,
                                       logic prefer_higher);
    logic res;
    if (sa == sb) begin
      res = (ia < ib);
    end else if (prefer_higher) begin
      res = (sa > sb);
    end else begin
      res = (sa < sb);
    end
    return res;
  endfunction

endpackage

### design/tks_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
`timescale 1ns / 1ps

interface tks_in_if;
  logic                               valid;
  logic                               ready;
  logic                               operation;
  logic signed [tks_pkg::SCORE_W-1:0] cand_score;
  logic [tks_pkg::ID_W-1:0]           cand_id;

  modport source (output valid, operation, cand_score, cand_id, input ready);
  modport sink   (input valid, operation, cand_score, cand_id, output ready);
endinterface

interface tks_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [tks_pkg::SCORE_W-1:0] out_score;
  logic [tks_pkg::ID_W-1:0]           out_id;
  logic                               last;

  modport source (output valid, out_score, out_id, last, input ready);
  modport sink   (input valid, out_score, out_id, last, output ready);
endinterface

interface tks_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tks_pkg::CFG_IDX_W-1:0]     index;
  logic [tks_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/top_k_selector.sv
// Consider request: inserted into the chain when accepted; a new one may follow every cycle while no finish drains.
// Finish request: N kept entries leave best first, one per cycle while the result channel takes them;
// the first passes the drain state and then the output register; requests are held off while the chain shifts out.
// Finish on an empty store gives no result.
// Reset (rst_n low, synchronous): store empty, capacity 16, lower score better.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module top_k_selector #(
  parameter int MAX_K = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tks_in_if.sink    in_bus,
  tks_out_if.source out_bus,
  tks_cfg_if.sink   cfg_bus
);
  import tks_pkg::*;

  localparam int CW = $clog2(MAX_K + 1);
  localparam int LW = (CW + 1 > CAP_W + 1) ? CW + 1 : CAP_W + 1;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                      state_r, state_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CAP_W-1:0]          capacity_r;
  logic                      prefer_higher_r;
  logic                      out_valid_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic [ID_W-1:0]           out_id_r;
  logic                      out_last_r;

  logic          in_acc;
  logic          consider_acc;
  logic          finish_acc;
  logic          out_load;
  logic [LW-1:0] cap_ext;
  logic [LW-1:0] cap_eff;
  logic [LW-1:0] count_ext;
  logic [LW-1:0] lim;
  logic          full;
  logic          cap_zero;

  entry_t          ents  [MAX_K];
  logic            ins_v [MAX_K];
  cell_ctl_t       ctls  [MAX_K];
  logic [MAX_K-1:0] valid_vec;

  // Request handshake
  assign in_bus.ready  = (state_r == ST_IDLE);
  assign in_acc        = in_bus.valid && in_bus.ready;
  assign consider_acc  = in_acc && (in_bus.operation == OP_CONSIDER);
  assign finish_acc    = in_acc && (in_bus.operation == OP_FINISH);
  assign cfg_bus.ready = 1'b1;

  // Effective capacity and fill limit
  assign cap_ext   = LW'(capacity_r);
  assign cap_eff   = (cap_ext > LW'(MAX_K)) ? LW'(MAX_K) : cap_ext;
  assign cap_zero  = (cap_eff == '0);
  assign count_ext = LW'(count_r);
  assign full      = (count_ext >= cap_eff);
  assign lim       = full ? count_ext : count_ext + LW'(1);

  // Drain one entry per cycle into the output register, while the result channel can take it
  assign out_load = (state_r == ST_DRAIN) && (!out_valid_r || out_bus.ready);

  // Build the chain
  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    assign ctls[i].load_en = consider_acc && !cap_zero && (LW'(i) < lim);
    assign ctls[i].shift   = out_load;
    assign valid_vec[i]    = ents[i].valid;

    tks_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .prefer_higher (prefer_higher_r),
      .ctl           (ctls[i]),
      .cand_score    (in_bus.cand_score),
      .cand_id       (in_bus.cand_id),
      .prev_ent      ((i == 0) ? ENTRY_EMPTY : ents[(i == 0) ? 0 : i - 1]),
      .prev_ins      ((i == 0) ? 1'b0 : ins_v[(i == 0) ? 0 : i - 1]),
      .next_ent      ((i == MAX_K - 1) ? ENTRY_EMPTY : ents[(i == MAX_K - 1) ? i : i + 1]),
      .ent           (ents[i]),
      .ins           (ins_v[i])
    );
  end

  // Sequencer: count and drain state
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    case (state_r)
      ST_IDLE: begin
        if (consider_acc && !cap_zero && !full) begin
          count_nxt = count_r + CW'(1);
        end
        if (finish_acc && (count_r != '0)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          count_nxt = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      count_r         <= '0;
      capacity_r      <= CAPACITY_RESET;
      prefer_higher_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_bus.valid) begin
        case (cfg_bus.index)
          REG_CAPACITY:      capacity_r      <= cfg_bus.data[CAP_W-1:0];
          REG_PREFER_HIGHER: prefer_higher_r <= cfg_bus.data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_score_r <= ents[0].score;
      out_id_r    <= ents[0].id;
      out_last_r  <= (count_r == CW'(1));
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.out_score = out_score_r;
  assign out_bus.out_id    = out_id_r;
  assign out_bus.last      = out_last_r;

  // Checks
  `TKS_ASSERT(a_count_range, clk, rst_n, LW'(count_r) <= LW'(MAX_K), "count above MAX_K")
  `TKS_ASSERT(a_count_valid, clk, rst_n, $countones(valid_vec) == int'(count_r), "valid bits disagree with count")
  `TKS_ASSERT(a_drain_nonempty, clk, rst_n, (state_r == ST_DRAIN) |-> (count_r != '0), "draining an empty store")
  `TKS_NEVER(a_head_valid, clk, rst_n, out_load && !ents[0].valid, "draining an invalid head entry")

endmodule

### design/tks_cell.sv
// One slot of the sorted chain: holds an entry, and each cycle inserts, shifts or keeps it.
`timescale 1ns / 1ps

module tks_cell (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               prefer_higher,
  input  tks_pkg::cell_ctl_t                 ctl,
  input  logic signed [tks_pkg::SCORE_W-1:0] cand_score,
  input  logic [tks_pkg::ID_W-1:0]           cand_id,
  input  tks_pkg::entry_t                    prev_ent,
  input  logic                               prev_ins,
  input  tks_pkg::entry_t                    next_ent,
  output tks_pkg::entry_t                    ent,
  output logic                               ins
);
  import tks_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // Candidate belongs at or above this slot
  assign ins = !ent_r.valid ||
               cand_better(cand_score, cand_id, ent_r.score, ent_r.id, prefer_higher);
  assign ent = ent_r;

  // Pick shift, insertion (take candidate or push down the left neighbor), or hold
  always_comb begin
    ent_nxt = ent_r;
    if (ctl.shift) begin
      ent_nxt = next_ent;
    end else if (ctl.load_en && ins) begin
      if (prev_ins) begin
        ent_nxt = prev_ent;
      end else begin
        ent_nxt.valid = 1'b1;
        ent_nxt.score = cand_score;
        ent_nxt.id    = cand_id;
      end
    end
  end

  // Reset the valid bit only; payload needs no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.score <= ent_nxt.score;
    ent_r.id    <= ent_nxt.id;
  end

endmodule

### test/top_k_selector_checker.sv
// Predictor and result checker for the top-k selector, watching all three channels.
`timescale 1ns / 1ps

module top_k_selector_checker #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  tks_in_if    in_mon,
  tks_out_if   out_mon,
  tks_cfg_if   cfg_mon,
  output int   mismatches,
  output int   pending,
  output int   checked
);

  import tks_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [ID_W-1:0]           id;
    logic                      last;
  } ranked_t;

  // Results still owed by the block, oldest first
  ranked_t ranked_q[$];

  // Shadow of the kept list, best first
  logic signed [SCORE_W-1:0] kept_score [DEPTH];
  logic [ID_W-1:0]           kept_id    [DEPTH];
  int unsigned               kept_n;
  logic [CAP_W-1:0]          capacity_reg;
  logic                      higher_wins;

  // Rank (sa, ia) strictly above (sb, ib); ties on score go to the smaller id
  function automatic bit outranks(logic signed [SCORE_W-1:0] sa, logic [ID_W-1:0] ia,
                                  logic signed [SCORE_W-1:0] sb, logic [ID_W-1:0] ib,
                                  logic hi);
    if (sa == sb) begin
      return ia < ib;
    end
    return hi ? (sa > sb) : (sa < sb);
  endfunction

  // Insert into the first n entries, behind anything that ranks at least as high
  function automatic void insert_entry(int unsigned n, logic signed [SCORE_W-1:0] sc,
                                       logic [ID_W-1:0] idv);
    int unsigned pos;
    pos = 0;
    while (pos < n && !outranks(sc, idv, kept_score[pos], kept_id[pos], higher_wins)) begin
      pos++;
    end
    for (int unsigned i = n; i > pos; i--) begin
      kept_score[i] = kept_score[i-1];
      kept_id[i]    = kept_id[i-1];
    end
    kept_score[pos] = sc;
    kept_id[pos]    = idv;
  endfunction

  always @(posedge clk) begin : track
    int unsigned lim;
    ranked_t     want;
    if (!rst_n) begin
      ranked_q.delete();
      kept_n       = 0;
      capacity_reg = CAPACITY_RESET;
      higher_wins  = 1'b0;
      mismatches  <= 0;
      checked     <= 0;
    end else begin
      // Follow register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_CAPACITY:      capacity_reg = cfg_mon.data[CAP_W-1:0];
          REG_PREFER_HIGHER: higher_wins  = cfg_mon.data[0];
          default: ;
        endcase
      end

      // Compare each emitted entry with the oldest one owed
      if (out_mon.valid && out_mon.ready) begin
        checked <= checked + 1;
        if (ranked_q.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("unexpected result: score %0d id %0d last %0b with nothing owed",
                     out_mon.out_score, out_mon.out_id, out_mon.last);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = ranked_q.pop_front();
          if (out_mon.out_score !== want.score || out_mon.out_id !== want.id ||
              out_mon.last !== want.last) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("result %0d: expected score %0d id %0d last %0b, got %0d %0d %0b",
                       checked, want.score, want.id, want.last,
                       out_mon.out_score, out_mon.out_id, out_mon.last);
            end
            mismatches <= mismatches + 1;
          end
        end
      end

      // Apply each accepted request to the shadow list
      if (in_mon.valid && in_mon.ready) begin
        lim = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
        if (in_mon.operation == OP_CONSIDER) begin
          if (lim != 0 && kept_n < lim) begin
            insert_entry(kept_n, in_mon.cand_score, in_mon.cand_id);
            kept_n++;
          end else if (lim != 0 && kept_n > 0 &&
                       outranks(in_mon.cand_score, in_mon.cand_id,
                                kept_score[kept_n-1], kept_id[kept_n-1], higher_wins)) begin
            insert_entry(kept_n - 1, in_mon.cand_score, in_mon.cand_id);
          end
        end else begin
          // Queue the kept list, best first, flagging the worst one
          for (int unsigned i = 0; i < kept_n; i++) begin
            want.score = kept_score[i];
            want.id    = kept_id[i];
            want.last  = (i + 1 == kept_n);
            ranked_q.insert(ranked_q.size(), want);
          end
          kept_n = 0;
        end
      end
    end
    pending <= ranked_q.size();
  end

endmodule

### test/top_k_selector_test.sv
// Stimulus, idling control and verdict for the top-k selector.
`timescale 1ns / 1ps

module top_k_selector_test;

  import tks_pkg::*;

  localparam int MAX_K        = 16;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 140;

  logic clk = 1'b0;
  logic rst_n;
  logic recv_ready = 1'b0;

  int send_idle = 0;
  int recv_idle = 0;
  int sent      = 0;
  int finishes  = 0;
  int writes    = 0;
  int quiet     = 0;
  int mismatches;
  int pending_results;
  int checked;

  tks_in_if  in_ch();
  tks_out_if out_ch();
  tks_cfg_if cfg_ch();

  assign out_ch.ready = recv_ready;

  top_k_selector #(.MAX_K(MAX_K)) dut (
    .clk,
    .rst_n,
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  top_k_selector_checker #(.DEPTH(MAX_K)) u_selector_check (
    .clk,
    .rst_n,
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending_results),
    .checked    (checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    recv_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("[top_k_selector] ERROR");
      $finish;
    end
  end

  // Scores: full range, tight cluster for ties, extremes, whole Q16.16 values
  function automatic logic signed [SCORE_W-1:0] rand_score();
    logic signed [SCORE_W-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = int'($urandom_range(8)) - 4;
      2: begin
        case ($urandom_range(3))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      default: v = (int'($urandom_range(400)) - 200) * 65536;
    endcase
    return v;
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    return $urandom_range(1) ? $urandom : $urandom_range(7);
  endfunction

  function automatic logic [CAP_W-1:0] rand_capacity();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CAP_W'($urandom_range(31, MAX_K + 1));
      2:       return CAP_W'(MAX_K);
      3:       return CAP_W'(1);
      default: return CAP_W'($urandom_range(MAX_K, 1));
    endcase
  endfunction

  // Present one request, idling first at random, and hold it until taken
  task automatic send_req(input logic op, input logic signed [SCORE_W-1:0] sc,
                          input logic [ID_W-1:0] idv);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.operation  <= op;
    in_ch.cand_score <= sc;
    in_ch.cand_id    <= idv;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    sent++;
    if (op == OP_FINISH) begin
      finishes++;
    end
  endtask

  task automatic send_finish();
    send_req(OP_FINISH, $urandom, $urandom);
  endtask

  // Hold off requests until every owed result is out, then let the block settle
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register, then drop valid for a cycle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
    writes++;
    @(posedge clk);
  endtask

  // Batches of candidates closed by a finish, with occasional reconfiguration
  task automatic run_batches(input int quota);
    int start;
    int n;
    start = sent;
    while (sent - start < quota) begin
      if ($urandom_range(3) == 0) begin
        wait_results_done();
        write_reg(REG_CAPACITY, CFG_DATA_W'(rand_capacity()));
        if ($urandom_range(1)) begin
          write_reg(REG_PREFER_HIGHER, $urandom_range(1));
        end
      end
      n = ($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(20);
      repeat (n) send_req(OP_CONSIDER, rand_score(), rand_id());
      send_finish();
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_CONSIDER;
    in_ch.cand_score = '0;
    in_ch.cand_id    = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_CAPACITY;
    cfg_ch.data      = '0;
    rst_n            = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 30;
    recv_idle = 52;

    // Reset settings: field extremes, score ties, an exact duplicate, then an empty finish
    send_req(OP_CONSIDER, 32'sh7FFF_FFFF, 32'h0000_0000);
    send_req(OP_CONSIDER, 32'sh8000_0000, 32'hFFFF_FFFF);
    send_req(OP_CONSIDER, 0, 5);
    send_req(OP_CONSIDER, 0, 3);
    send_req(OP_CONSIDER, 0, 3);
    send_req(OP_CONSIDER, -1, 1);
    send_finish();
    send_finish();

    // Full store of two: an equal candidate is refused, a better one replaces the worst
    wait_results_done();
    write_reg(REG_PREFER_HIGHER, 1);
    write_reg(REG_CAPACITY, 2);
    send_req(OP_CONSIDER, 5 * 65536, 10);
    send_req(OP_CONSIDER, 5 * 65536, 10);
    send_req(OP_CONSIDER, 5 * 65536, 10);
    send_req(OP_CONSIDER, 7 * 65536, 1);
    send_finish();

    // Capacity dropped below the number kept: the store keeps all four
    wait_results_done();
    write_reg(REG_CAPACITY, MAX_K);
    send_req(OP_CONSIDER, 1, 9);
    send_req(OP_CONSIDER, 2, 8);
    send_req(OP_CONSIDER, 3, 7);
    send_req(OP_CONSIDER, 4, 6);
    wait_results_done();
    write_reg(REG_CAPACITY, 1);
    send_req(OP_CONSIDER, 9, 2);
    send_req(OP_CONSIDER, 0, 0);
    send_finish();

    // Capacity zero: candidates dropped, finish emits nothing
    wait_results_done();
    write_reg(REG_CAPACITY, 0);
    send_req(OP_CONSIDER, rand_score(), rand_id());
    send_req(OP_CONSIDER, rand_score(), rand_id());
    send_finish();

    // Capacity above the store size, then the random batches
    wait_results_done();
    write_reg(REG_CAPACITY, 31);
    write_reg(REG_PREFER_HIGHER, 0);
    run_batches(PHASE_ITEMS);

    send_idle = 52;
    recv_idle = 30;
    run_batches(PHASE_ITEMS);

    send_idle = 0;
    recv_idle = 0;
    run_batches(PHASE_ITEMS);

    wait_results_done();
    $display("covered %0d requests (%0d finish) and %0d register writes; %0d results checked",
             sent, finishes, writes, checked);
    if (mismatches == 0 && pending_results == 0) begin
      $display("[top_k_selector] OK");
    end else begin
      $display("[top_k_selector] ERROR");
    end
    $finish;
  end

endmodule
